// ===== design/hrw_pkg.sv =====
// shared types and constants of the heating rate watchdog
package hrw_pkg;

  localparam int HEADS          = 8;
  localparam int PORT_HEADS     = 8;
  localparam int HEAD_BITS      = 3;
  localparam int WINDOW_SAMPLES = 10;
  localparam int READING_BITS   = 12;
  localparam int SUM_BITS       = 12;
  localparam int CNT_BITS       = $clog2(WINDOW_SAMPLES + 1);

  localparam int IV_BITS        = 8;
  localparam int TRIP_BITS      = 4;
  localparam int RATE_BITS      = 8;
  localparam int LIM_BITS       = IV_BITS + 7;
  localparam int HEATING_LIMIT  = 25;
  localparam int COOLING_LIMIT  = 80;
  localparam int RATE_MAX       = 255;

  localparam int IV_RESET       = 3;
  localparam int TRIP_RESET     = 1;

  localparam int QDEPTH         = 2;
  localparam int QPTR_BITS      = $clog2(QDEPTH);
  localparam int QCNT_BITS      = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP     = 1'b1;

  // one word handed from the front to the back
  typedef struct packed {
    logic                                 clr;
    logic                                 cmp;
    logic [PORT_HEADS-1:0][SUM_BITS-1:0]  cur;
    logic [PORT_HEADS-1:0][SUM_BITS-1:0]  prev;
  } job_t;

  // one result word
  typedef struct packed {
    logic                 done;
    logic                 err;
    logic [HEAD_BITS-1:0] head;
    logic [RATE_BITS-1:0] rate;
    logic                 trip;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SCAN = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

endpackage

// ===== design/heating_rate_watchdog.sv =====
// top level of the heater heating and cooling rate watchdog
// flow: the back picks a word off the queue, scans the heads one by one for a compared window,
//   runs the serial divide on the first failing head, then hands the result to the output slot
// the back works on one word at a time and waits at the hand-off while the output slot is full;
//   a two-word queue lets the front keep accepting while the back scans and divides
// reset: synchronous, rst_n low; sums, counters and queue cleared, priming window armed,
//   interval 3 and trip limit 1
module heating_rate_watchdog import hrw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample word in
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [READING_BITS-1:0]  in_reading_head_0,
  input  logic [READING_BITS-1:0]  in_reading_head_1,
  input  logic [READING_BITS-1:0]  in_reading_head_2,
  input  logic [READING_BITS-1:0]  in_reading_head_3,
  input  logic [READING_BITS-1:0]  in_reading_head_4,
  input  logic [READING_BITS-1:0]  in_reading_head_5,
  input  logic [READING_BITS-1:0]  in_reading_head_6,
  input  logic [READING_BITS-1:0]  in_reading_head_7,
  input  logic                     in_clear_count,
  // result word out
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_window_done,
  output logic                     out_rate_error,
  output logic [HEAD_BITS-1:0]     out_error_head,
  output logic [RATE_BITS-1:0]     out_error_rate,
  output logic                     out_trip_shutdown,
  // register writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [PORT_HEADS-1:0][READING_BITS-1:0] reading;
  logic                 in_accept;
  job_t                 front_job;
  job_t                 q_head;
  logic                 q_empty;
  logic                 q_pop;
  logic                 out_ready;
  logic                 res_valid;
  res_t                 res;

  // config registers
  logic [IV_BITS-1:0]   iv_r, iv_nxt;
  logic [TRIP_BITS-1:0] trip_lim_r, trip_lim_nxt;

  // output register, parts the back from the consumer
  res_t                 out_r;
  logic                 out_valid_r, out_valid_nxt;

  // head readings gathered into one vector, lane per head
  assign reading[0] = in_reading_head_0;
  assign reading[1] = in_reading_head_1;
  assign reading[2] = in_reading_head_2;
  assign reading[3] = in_reading_head_3;
  assign reading[4] = in_reading_head_4;
  assign reading[5] = in_reading_head_5;
  assign reading[6] = in_reading_head_6;
  assign reading[7] = in_reading_head_7;

  // a word enters the front and the queue in the same cycle
  assign in_accept = in_push & ~in_full;

  hrw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .reading (reading),
    .clr     (in_clear_count),
    .job     (front_job)
  );

  hrw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .din   (front_job),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  // back may hand off when the output slot is free or being drained
  assign out_ready = ~out_valid_r | out_pop;

  hrw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .iv        (iv_r),
    .trip_lim  (trip_lim_r),
    .out_ready (out_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // register write decode
  always_comb begin
    iv_nxt       = iv_r;
    trip_lim_nxt = trip_lim_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL: iv_nxt       = cfg_wdata[IV_BITS-1:0];
        CFG_TRIP:     trip_lim_nxt = cfg_wdata[TRIP_BITS-1:0];
        default: begin
          iv_nxt = iv_r;
        end
      endcase
    end
  end

  // result slot valid tracking
  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r        <= IV_BITS'(IV_RESET);
      trip_lim_r  <= TRIP_BITS'(TRIP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      iv_r        <= iv_nxt;
      trip_lim_r  <= trip_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_empty         = ~out_valid_r;
  assign out_window_done   = out_r.done;
  assign out_rate_error    = out_r.err;
  assign out_error_head    = out_r.head;
  assign out_error_rate    = out_r.rate;
  assign out_trip_shutdown = out_r.trip;

endmodule

// ===== design/hrw_front.sv =====
// window accumulator: adds reading/window to each head sum and closes windows
module hrw_front import hrw_pkg::*; (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  logic [PORT_HEADS-1:0][READING_BITS-1:0] reading,
  input  logic                                    clr,
  output job_t                                    job
);

  localparam int RECIP_SHIFT = READING_BITS + 4;
  localparam int RECIP       = (2**RECIP_SHIFT + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
  localparam int PROD_BITS   = READING_BITS + RECIP_SHIFT;

  // floor(r / WINDOW_SAMPLES) by reciprocal multiply
  function automatic logic [READING_BITS-1:0] div_window(input logic [READING_BITS-1:0] r);
    logic [PROD_BITS-1:0] p;
    p = PROD_BITS'(r) * PROD_BITS'(RECIP);
    return p[RECIP_SHIFT +: READING_BITS];
  endfunction

  logic [PORT_HEADS-1:0][SUM_BITS-1:0] cur_r, cur_nxt;
  logic [PORT_HEADS-1:0][SUM_BITS-1:0] prev_r, prev_nxt;
  logic [PORT_HEADS-1:0][SUM_BITS-1:0] sum_new;
  logic [CNT_BITS-1:0]                 cnt_r, cnt_nxt;
  logic                                prime_r, prime_nxt;
  logic                                closing;

  always_comb begin
    for (int h = 0; h < PORT_HEADS; h++) begin
      if (h < HEADS) begin
        sum_new[h] = cur_r[h] + SUM_BITS'(div_window(reading[h]));
      end else begin
        sum_new[h] = '0;
      end
    end
    closing = (cnt_r == CNT_BITS'(WINDOW_SAMPLES - 1));

    job.clr  = clr;
    job.cmp  = closing & ~prime_r;
    job.cur  = sum_new;
    job.prev = prev_r;

    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    prime_nxt = prime_r;
    if (accept) begin
      if (closing) begin
        prev_nxt  = sum_new;
        cur_nxt   = '0;
        cnt_nxt   = '0;
        prime_nxt = 1'b0;
      end else begin
        cur_nxt = sum_new;
        cnt_nxt = cnt_r + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
      prime_r <= 1'b1;
    end else begin
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      prime_r <= prime_nxt;
    end
  end

endmodule

// ===== design/hrw_queue.sv =====
// short word queue between the front and the back
module hrw_queue import hrw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full  = (cnt_r == QCNT_BITS'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    do_push = push & ~full;
    do_pop  = pop & ~empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/hrw_back.sv =====
// window check sequencer: per-head scan, serial divider, error counter
module hrw_back import hrw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  job_t                 job,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [IV_BITS-1:0]   iv,
  input  logic [TRIP_BITS-1:0] trip_lim,
  input  logic                 out_ready,
  output logic                 res_valid,
  output res_t                 res
);

  localparam int STEP_BITS = $clog2(SUM_BITS);

  back_state_t            state_r, state_nxt;
  logic [HEAD_BITS-1:0]   idx_r, idx_nxt;
  logic [TRIP_BITS-1:0]   cnt_r, cnt_nxt;
  logic                   err_r, err_nxt;
  logic [HEAD_BITS-1:0]   head_r, head_nxt;
  logic [RATE_BITS-1:0]   rate_r, rate_nxt;
  logic [SUM_BITS-1:0]    mag_r, mag_nxt;
  logic [SUM_BITS-1:0]    quo_r, quo_nxt;
  logic [IV_BITS-1:0]     rem_r, rem_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;

  logic [SUM_BITS:0]      diff;
  logic [SUM_BITS:0]      diff_abs;
  logic [SUM_BITS-1:0]    mag;
  logic                   neg;
  logic [LIM_BITS-1:0]    heat_lim, cool_lim;
  logic                   fail;
  logic [IV_BITS:0]       rem_sh;
  logic                   ge;
  logic [IV_BITS:0]       rem_sub;
  logic [SUM_BITS-1:0]    quo_full;
  logic [TRIP_BITS-1:0]   cnt_inc;
  logic                   trip;

  always_comb begin
    // per-head compare of the closed window against the previous one
    diff     = {1'b0, job.cur[idx_r]} - {1'b0, job.prev[idx_r]};
    neg      = diff[SUM_BITS];
    diff_abs = neg ? (~diff + (SUM_BITS+1)'(1)) : diff;
    mag      = diff_abs[SUM_BITS-1:0];
    heat_lim = LIM_BITS'(iv) * LIM_BITS'(HEATING_LIMIT);
    cool_lim = LIM_BITS'(iv) * LIM_BITS'(COOLING_LIMIT);
    fail     = neg ? (LIM_BITS'(mag) > heat_lim) : (LIM_BITS'(mag) > cool_lim);

    // one restoring divide step
    rem_sh   = {rem_r, mag_r[SUM_BITS-1]};
    ge       = (rem_sh >= {1'b0, iv});
    rem_sub  = rem_sh - {1'b0, iv};
    quo_full = {quo_r[SUM_BITS-2:0], ge};

    cnt_inc  = cnt_r + TRIP_BITS'(1);
    trip     = err_r && (cnt_inc >= trip_lim);

    res.done = job.cmp;
    res.err  = err_r;
    res.head = head_r;
    res.rate = rate_r;
    res.trip = trip;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    head_nxt  = head_r;
    rate_nxt  = rate_r;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (job.clr) begin
            cnt_nxt = '0;
          end
          err_nxt  = 1'b0;
          head_nxt = '0;
          rate_nxt = '0;
          idx_nxt  = '0;
          state_nxt = job.cmp ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (fail) begin
          err_nxt  = 1'b1;
          head_nxt = idx_r;
          if (iv == '0) begin
            rate_nxt  = RATE_BITS'(RATE_MAX);
            state_nxt = B_DONE;
          end else begin
            mag_nxt   = mag;
            quo_nxt   = '0;
            rem_nxt   = '0;
            step_nxt  = STEP_BITS'(SUM_BITS - 1);
            state_nxt = B_DIV;
          end
        end else if (idx_r == HEAD_BITS'(HEADS - 1)) begin
          state_nxt = B_DONE;
        end else begin
          idx_nxt = idx_r + HEAD_BITS'(1);
        end
      end
      B_DIV: begin
        rem_nxt = ge ? rem_sub[IV_BITS-1:0] : rem_sh[IV_BITS-1:0];
        quo_nxt = quo_full;
        mag_nxt = {mag_r[SUM_BITS-2:0], 1'b0};
        if (step_r == '0) begin
          rate_nxt  = (quo_full > SUM_BITS'(RATE_MAX)) ? RATE_BITS'(RATE_MAX)
                                                      : quo_full[RATE_BITS-1:0];
          state_nxt = B_DONE;
        end else begin
          step_nxt = step_r - STEP_BITS'(1);
        end
      end
      B_DONE: begin
        if (out_ready) begin
          res_valid = 1'b1;
          q_pop     = 1'b1;
          if (err_r) begin
            cnt_nxt = trip ? '0 : cnt_inc;
          end
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
      head_r  <= '0;
      rate_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      head_r  <= head_nxt;
      rate_r  <= rate_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== verif/tb_heating_rate_watchdog.sv =====
// testbench of the heater heating and cooling rate watchdog
`timescale 1ns / 100ps

module tb_heating_rate_watchdog;
  import hrw_pkg::*;

  localparam int PHASE_ITEMS   = 280;   // random words per register setting
  localparam int SETTLE_CYCLES = 24;    // longest compare path plus margin
  localparam int IDLE_LIMIT    = 5000;  // cycles without any handshake before giving up

  // one sample word as the sender sees it
  typedef struct packed {
    logic                                    clear;
    logic [HEADS-1:0][READING_BITS-1:0]      reading;
  } sample_t;

  // window predictor plus queue of results still owed by the block
  class rate_scoreboard;
    logic [IV_BITS-1:0]   interval;
    logic [TRIP_BITS-1:0] trip_limit;
    logic [SUM_BITS-1:0]  cur_sum [HEADS];
    logic [SUM_BITS-1:0]  prev_sum [HEADS];
    logic [3:0]           fill;
    logic                 priming;
    logic [3:0]           err_count;
    res_t                 due_results [$];
    int                   failures;

    function new();
      interval   = IV_BITS'(IV_RESET);
      trip_limit = TRIP_BITS'(TRIP_RESET);
      for (int h = 0; h < HEADS; h++) begin
        cur_sum[h]  = '0;
        prev_sum[h] = '0;
      end
      fill      = '0;
      priming   = 1'b1;
      err_count = '0;
      failures  = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_sample(sample_t s);
      res_t r;
      int   diff;
      int   mag;
      int   q;
      r = '0;
      if (s.clear) err_count = '0;
      for (int h = 0; h < HEADS; h++)
        cur_sum[h] = cur_sum[h] + SUM_BITS'(s.reading[h] / WINDOW_SAMPLES);
      fill = fill + 4'd1;
      if (fill >= WINDOW_SAMPLES) begin
        if (priming) begin
          priming = 1'b0;
        end else begin
          r.done = 1'b1;
          for (int h = 0; h < HEADS; h++) begin
            diff = int'(cur_sum[h]) - int'(prev_sum[h]);
            if (!r.err && (diff < -(HEATING_LIMIT * int'(interval)) ||
                           diff > COOLING_LIMIT * int'(interval))) begin
              r.err  = 1'b1;
              r.head = HEAD_BITS'(h);
              mag    = (diff < 0) ? -diff : diff;
              if (interval == 0) begin
                q = RATE_MAX;
              end else begin
                q = mag / int'(interval);
                if (q > RATE_MAX) q = RATE_MAX;
              end
              r.rate = RATE_BITS'(q);
            end
          end
          if (r.err) begin
            err_count = err_count + 4'd1;
            if (err_count >= trip_limit) begin
              r.trip    = 1'b1;
              err_count = '0;
            end
          end
        end
        for (int h = 0; h < HEADS; h++) begin
          prev_sum[h] = cur_sum[h];
          cur_sum[h]  = '0;
        end
        fill = '0;
      end
      due_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding");
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.done !== want.done) begin
        $error("window_done: expected %0d, got %0d", want.done, got.done);
        failures++;
      end
      if (got.err !== want.err) begin
        $error("rate_error: expected %0d, got %0d", want.err, got.err);
        failures++;
      end
      if (got.head !== want.head) begin
        $error("error_head: expected %0d, got %0d", want.head, got.head);
        failures++;
      end
      if (got.rate !== want.rate) begin
        $error("error_rate: expected %0d, got %0d", want.rate, got.rate);
        failures++;
      end
      if (got.trip !== want.trip) begin
        $error("trip_shutdown: expected %0d, got %0d", want.trip, got.trip);
        failures++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic [READING_BITS-1:0]  in_reading_head_0;
  logic [READING_BITS-1:0]  in_reading_head_1;
  logic [READING_BITS-1:0]  in_reading_head_2;
  logic [READING_BITS-1:0]  in_reading_head_3;
  logic [READING_BITS-1:0]  in_reading_head_4;
  logic [READING_BITS-1:0]  in_reading_head_5;
  logic [READING_BITS-1:0]  in_reading_head_6;
  logic [READING_BITS-1:0]  in_reading_head_7;
  logic                     in_clear_count;
  logic                     out_empty;
  logic                     out_pop;
  logic                     out_window_done;
  logic                     out_rate_error;
  logic [HEAD_BITS-1:0]     out_error_head;
  logic [RATE_BITS-1:0]     out_error_rate;
  logic                     out_trip_shutdown;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  rate_scoreboard sb;
  int             idle_cycles = 0;
  int             words_sent = 0;
  int             cur_iv = IV_RESET;   // interval in force, steers the level steps
  int             level [HEADS];       // per-head temperature level the readings hover around
  bit             in_burst = 1'b0;     // sender runs back to back while set
  bit             out_burst = 1'b0;    // receiver pops back to back while set

  heating_rate_watchdog u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_reading_head_0 (in_reading_head_0),
    .in_reading_head_1 (in_reading_head_1),
    .in_reading_head_2 (in_reading_head_2),
    .in_reading_head_3 (in_reading_head_3),
    .in_reading_head_4 (in_reading_head_4),
    .in_reading_head_5 (in_reading_head_5),
    .in_reading_head_6 (in_reading_head_6),
    .in_reading_head_7 (in_reading_head_7),
    .in_clear_count    (in_clear_count),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_window_done   (out_window_done),
    .out_rate_error    (out_rate_error),
    .out_error_head    (out_error_head),
    .out_error_rate    (out_error_rate),
    .out_trip_shutdown (out_trip_shutdown),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hang detector: pre-edge values of both handshakes, any accept restarts the count
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // push one sample word after a random gap; returns at the edge that took it
  task automatic send_sample(sample_t s);
    int   gap;
    logic was_full;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    // push stays high from the last word when there is no gap
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_reading_head_0 <= s.reading[0];
    in_reading_head_1 <= s.reading[1];
    in_reading_head_2 <= s.reading[2];
    in_reading_head_3 <= s.reading[3];
    in_reading_head_4 <= s.reading[4];
    in_reading_head_5 <= s.reading[5];
    in_reading_head_6 <= s.reading[6];
    in_reading_head_7 <= s.reading[7];
    in_clear_count    <= s.clear;
    // full is looked at mid-cycle, well away from the edge
    do begin
      @(negedge clk);
      was_full = in_full;
      @(posedge clk);
    end while (was_full);
    sb.note_sample(s);
    words_sent++;
  endtask

  // pop one result word after a random gap and check it
  task automatic take_result();
    int   gap;
    logic was_empty;
    res_t got;
    if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    gap = out_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      out_pop <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    out_pop <= 1'b1;
    do begin
      @(negedge clk);
      was_empty = out_empty;
      got.done  = out_window_done;
      got.err   = out_rate_error;
      got.head  = out_error_head;
      got.rate  = out_error_rate;
      got.trip  = out_trip_shutdown;
      @(posedge clk);
    end while (was_empty);
    sb.check_result(got);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back while the block is idle
  task automatic load_settings(input logic [IV_BITS-1:0] iv, input logic [TRIP_BITS-1:0] lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERVAL;
    cfg_wdata <= CFG_DATA_BITS'(iv);
    @(posedge clk);
    cfg_index <= CFG_TRIP;
    cfg_wdata <= CFG_DATA_BITS'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.interval   = iv;
    sb.trip_limit = lim;
    cur_iv        = int'(iv);
  endtask

  // directed opener under reset settings (interval 3, trip at first error)
  task automatic run_directed();
    sample_t s;
    // priming window of all-zero readings, counter clear on the first word
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      s = '0;
      s.clear = (i == 0);
      send_sample(s);
    end
    // head 3 jumps to full scale: cooling too fast, rate saturates, trips at once
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      s = '0;
      s.reading[3] = '1;
      send_sample(s);
    end
    // a few bit-pattern words to start the next window
    for (int i = 0; i < 5; i++) begin
      for (int h = 0; h < HEADS; h++)
        s.reading[h] = ((h + i) % 2 == 0) ? 12'hAAA : 12'h555;
      s.clear = (i == 2);
      send_sample(s);
    end
  endtask

  // random words built around per-head levels that step at window boundaries
  task automatic run_random(int count);
    sample_t s;
    int      r;
    repeat (count) begin
      if (words_sent % WINDOW_SAMPLES == 0) begin
        for (int h = 0; h < HEADS; h++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: level[h] = level[h] + $urandom_range(0, 40) - 20;
            3, 4:    level[h] = level[h] - HEATING_LIMIT * cur_iv + $urandom_range(0, 20) - 10;
            5, 6:    level[h] = level[h] + COOLING_LIMIT * cur_iv + $urandom_range(0, 20) - 10;
            7:       level[h] = $urandom_range(0, 4095);
            default: ;
          endcase
          if (level[h] < 0) level[h] = 0;
          if (level[h] > 4095) level[h] = 4095;
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        // noise word, any bit pattern
        for (int h = 0; h < HEADS; h++)
          s.reading[h] = READING_BITS'($urandom_range(0, 4095));
      end else begin
        for (int h = 0; h < HEADS; h++) begin
          r = level[h] + $urandom_range(0, 6) - 3;
          if (r < 0) r = 0;
          if (r > 4095) r = 4095;
          s.reading[h] = READING_BITS'(r);
        end
      end
      s.clear = ($urandom_range(0, 24) == 0);
      send_sample(s);
    end
  endtask

  initial begin
    sb                = new;
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_reading_head_0 = '0;
    in_reading_head_1 = '0;
    in_reading_head_2 = '0;
    in_reading_head_3 = '0;
    in_reading_head_4 = '0;
    in_reading_head_5 = '0;
    in_reading_head_6 = '0;
    in_reading_head_7 = '0;
    in_clear_count    = 1'b0;
    out_pop           = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_INTERVAL;
    cfg_wdata         = '0;
    for (int h = 0; h < HEADS; h++) level[h] = 2048;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      forever take_result();
    join_none

    run_directed();
    run_random(PHASE_ITEMS);

    // zero interval and zero trip limit: any change errors and every error trips
    load_settings(8'd0, 4'd0);
    run_random(PHASE_ITEMS);
    // tightest nonzero limits, deepest error count before tripping
    load_settings(8'd1, 4'd15);
    run_random(PHASE_ITEMS);
    // widest interval: limits beyond any reachable difference
    load_settings(8'd255, 4'd1);
    run_random(PHASE_ITEMS);
    load_settings(8'd2, 4'd3);
    run_random(PHASE_ITEMS);
    load_settings(IV_BITS'($urandom_range(1, 12)), TRIP_BITS'($urandom_range(1, 15)));
    run_random(PHASE_ITEMS);
    load_settings(8'd1, 4'd2);
    run_random(PHASE_ITEMS);

    // wait for the tail, then a quiet stretch to catch stray words
    drain();
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== heating_rate_watchdog.f =====
design/hrw_pkg.sv
design/hrw_front.sv
design/hrw_queue.sv
design/hrw_back.sv
design/heating_rate_watchdog.sv
verif/tb_heating_rate_watchdog.sv
